// ===== hdl/decimal_timestamp_parser_top_defines.svh =====
// ----------------------------------------------------------------------------
// decimal_timestamp_parser_top_defines.svh
// Assertion macros shared by the timestamp parser checker.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TIMESTAMP_PARSER_TOP_DEFINES_SVH
`define DECIMAL_TIMESTAMP_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define DTP_ASSERT_NXT_ALL(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dtp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_pkg
// Character codes, error codes and helpers for the decimal timestamp parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

    localparam int SEC_W    = 64;
    localparam int FRAC_W   = 30;
    localparam int PLACES_W = 4;
    localparam int TS_W     = 64;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_EMPTY     = 3'd1;
    localparam logic [2:0] ERR_NEGATIVE  = 3'd2;
    localparam logic [2:0] ERR_BAD_SEC   = 3'd3;
    localparam logic [2:0] ERR_BAD_DOT   = 3'd4;
    localparam logic [2:0] ERR_BAD_FRAC  = 3'd5;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd6;

    localparam logic [1:0] PH_START    = 2'd0;
    localparam logic [1:0] PH_SECONDS  = 2'd1;
    localparam logic [1:0] PH_FRACTION = 2'd2;

    localparam logic FMT_MS = 1'b0;
    localparam logic FMT_NS = 1'b1;

    localparam logic [PLACES_W-1:0] PLACES_NS = 4'd9;
    localparam logic [PLACES_W-1:0] PLACES_MS = 4'd3;

    localparam logic [FRAC_W-1:0] UNIT_MAX_NS = 30'd999999999;
    localparam logic [FRAC_W-1:0] UNIT_MAX_MS = 30'd999;

    localparam logic [SEC_W-1:0] SEC_MAX_NS = 64'h0000_0000_FFFF_FFFF;
    localparam logic [SEC_W-1:0] SEC_MAX_MS = '1;

    // finished text, handed from the parse stage to the step stage
    typedef struct packed {
        logic [SEC_W-1:0]  sec;
        logic [FRAC_W-1:0] frac;
        logic              seen;
        logic [2:0]        err;
        logic              empty_start;
        logic              plus;
        logic              minus;
        logic              fmt;
    } t_snap;

    function automatic logic [FRAC_W-1:0] dec_pow(input logic [PLACES_W-1:0] idx);
        logic [FRAC_W-1:0] v;
        case (idx)
            4'd0:    v = 30'd1;
            4'd1:    v = 30'd10;
            4'd2:    v = 30'd100;
            4'd3:    v = 30'd1000;
            4'd4:    v = 30'd10000;
            4'd5:    v = 30'd100000;
            4'd6:    v = 30'd1000000;
            4'd7:    v = 30'd10000000;
            4'd8:    v = 30'd100000000;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/dtp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_in_if
// Character stream channel: one text character per item.
// ----------------------------------------------------------------------------
interface dtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_text;

    modport source (output valid, output char_code, output last_char, output empty_text,
                    input ready);
    modport sink   (input valid, input char_code, input last_char, input empty_text,
                    output ready);
    modport monitor (input valid, input ready, input char_code, input last_char,
                     input empty_text);
endinterface

// ===== hdl/dtp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_out_if
// Result channel: packed timestamp, short-form flag and error code.
// ----------------------------------------------------------------------------
interface dtp_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] timestamp;
    logic        short_form;
    logic [2:0]  error_code;

    modport source (output valid, output timestamp, output short_form, output error_code,
                    input ready);
    modport sink   (input valid, input timestamp, input short_form, input error_code,
                    output ready);
    modport monitor (input valid, input ready, input timestamp, input short_form,
                     input error_code);
endinterface

// ===== hdl/decimal_timestamp_parser_top.sv =====
`timescale 1ns / 1ps
// A result is offered once it has passed the snapshot, step and pack registers.
// Throughput: one character per cycle unless the result channel stalls; the
// multiply-by-ten seconds update and the fraction digit add close in the single parse stage each cycle.
// Results pass a step stage and a pack stage, each with its own valid bit.
// Reset (i_rst_n low, synchronous): text restarts, format returns to ns mode,
// pipeline empties.
// ----------------------------------------------------------------------------
// decimal_timestamp_parser_top
// Parses a decimal timestamp text character by character and packs it into
// a seconds/nanoseconds word or a millisecond count.
// ----------------------------------------------------------------------------
module decimal_timestamp_parser_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    dtp_in_if.sink        i_in,
    dtp_out_if.source     o_out
);
    import dtp_pkg::*;

    // configuration and parse state
    logic                r_fmt;
    logic [1:0]          r_phase;
    logic [SEC_W-1:0]    r_sec;
    logic                r_seen;
    logic [FRAC_W-1:0]   r_frac;
    logic [PLACES_W-1:0] r_places;
    logic [2:0]          r_err;

    logic [1:0]          n_phase;
    logic [SEC_W-1:0]    n_sec;
    logic                n_seen;
    logic [FRAC_W-1:0]   n_frac;
    logic [PLACES_W-1:0] n_places;
    logic [2:0]          n_err;

    // pipeline
    logic                r_b_valid;
    t_snap               r_b;
    t_snap               n_b;
    logic                r_c_valid;
    logic [SEC_W-1:0]    r_c_sec;
    logic [FRAC_W-1:0]   r_c_frac;
    logic [2:0]          r_c_err;
    logic                r_c_fmt;
    logic [SEC_W-1:0]    n_c_sec;
    logic [FRAC_W-1:0]   n_c_frac;
    logic [2:0]          n_c_err;
    logic                r_out_valid;
    logic [TS_W-1:0]     r_ts;
    logic                r_short;
    logic [2:0]          r_out_err;
    logic [TS_W-1:0]     n_ts;
    logic                n_short;
    logic [2:0]          n_out_err;

    logic                c_ready;
    logic                b_ready;
    logic                in_acc;
    logic                is_digit;
    logic                is_sign;
    logic                take_en;
    logic [3:0]          dgt;
    logic [SEC_W+3:0]    acc10;
    logic [FRAC_W+3:0]   frac_term;
    logic [PLACES_W-1:0] places_rst;

    assign c_ready    = !r_out_valid || o_out.ready;
    assign b_ready    = !r_c_valid || c_ready;
    assign i_in.ready = !r_b_valid || b_ready;
    assign in_acc     = i_in.valid && i_in.ready;

    assign places_rst = (r_fmt == FMT_NS) ? PLACES_NS : PLACES_MS;

    // ---------------- parse stage ----------------
    assign is_digit = (i_in.char_code >= CH_ZERO) && (i_in.char_code <= CH_NINE);
    assign is_sign  = (i_in.char_code == CH_PLUS) || (i_in.char_code == CH_MINUS);
    assign dgt      = i_in.char_code[3:0];
    // a final sign is the unit step, not text
    assign take_en  = !i_in.empty_text && !(i_in.last_char && is_sign);

    // acc*10 + d; anything above bit 63 means the seconds overflowed
    assign acc10     = ({4'b0, r_sec} << 3) + ({4'b0, r_sec} << 1) + {{SEC_W{1'b0}}, dgt};
    assign frac_term = {{FRAC_W{1'b0}}, dgt} * {4'b0, dec_pow(r_places - 4'd1)};

    always_comb begin
        n_phase  = r_phase;
        n_sec    = r_sec;
        n_seen   = r_seen;
        n_frac   = r_frac;
        n_places = r_places;
        n_err    = r_err;
        if (r_err == ERR_OK) begin
            if (r_phase == PH_START && i_in.char_code == CH_MINUS) begin
                n_err = ERR_NEGATIVE;
            end else if (r_phase == PH_START || r_phase == PH_SECONDS) begin
                n_phase = PH_SECONDS;
                if (is_digit) begin
                    n_seen = 1'b1;
                    if (acc10[SEC_W+3:SEC_W] != 4'd0) begin
                        n_sec = '1;
                        n_err = ERR_BAD_SEC;
                    end else begin
                        n_sec = acc10[SEC_W-1:0];
                    end
                end else if (!r_seen) begin
                    n_err = ERR_BAD_SEC;
                end else if (i_in.char_code == CH_DOT) begin
                    n_phase = PH_FRACTION;
                end else begin
                    n_err = ERR_BAD_DOT;
                end
            end else begin
                if (!is_digit) begin
                    n_err = ERR_BAD_FRAC;
                end else if (r_places != '0) begin
                    // digits past the unit resolution are checked only
                    n_places = r_places - 4'd1;
                    n_frac   = r_frac + frac_term[FRAC_W-1:0];
                end
            end
        end
    end

    always_comb begin
        n_b.sec         = take_en ? n_sec : r_sec;
        n_b.frac        = take_en ? n_frac : r_frac;
        n_b.seen        = take_en ? n_seen : r_seen;
        n_b.err         = take_en ? n_err : r_err;
        n_b.empty_start = i_in.empty_text && r_phase == PH_START && r_err == ERR_OK;
        n_b.plus        = !i_in.empty_text && i_in.char_code == CH_PLUS;
        n_b.minus       = !i_in.empty_text && i_in.char_code == CH_MINUS;
        n_b.fmt         = r_fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt    <= FMT_NS;
            r_phase  <= PH_START;
            r_sec    <= '0;
            r_seen   <= 1'b0;
            r_frac   <= '0;
            r_places <= PLACES_NS;
            r_err    <= ERR_OK;
        end else if (i_cfg_wr_en) begin
            r_fmt    <= i_cfg_wr_data;
            r_phase  <= PH_START;
            r_sec    <= '0;
            r_seen   <= 1'b0;
            r_frac   <= '0;
            r_places <= (i_cfg_wr_data == FMT_NS) ? PLACES_NS : PLACES_MS;
            r_err    <= ERR_OK;
        end else if (in_acc) begin
            if (i_in.last_char) begin
                r_phase  <= PH_START;
                r_sec    <= '0;
                r_seen   <= 1'b0;
                r_frac   <= '0;
                r_places <= places_rst;
                r_err    <= ERR_OK;
            end else if (!i_in.empty_text) begin
                r_phase  <= n_phase;
                r_sec    <= n_sec;
                r_seen   <= n_seen;
                r_frac   <= n_frac;
                r_places <= n_places;
                r_err    <= n_err;
            end
        end
    end

    // ---------------- step stage ----------------
    always_comb begin
        logic [FRAC_W-1:0] unit_max;
        logic [SEC_W-1:0]  sec_max;
        unit_max = (r_b.fmt == FMT_NS) ? UNIT_MAX_NS : UNIT_MAX_MS;
        sec_max  = (r_b.fmt == FMT_NS) ? SEC_MAX_NS : SEC_MAX_MS;
        n_c_sec  = r_b.sec;
        n_c_frac = r_b.frac;
        if (r_b.empty_start) begin
            n_c_err = ERR_EMPTY;
        end else if (r_b.err == ERR_OK && !r_b.seen) begin
            n_c_err = ERR_BAD_SEC;
        end else begin
            n_c_err = r_b.err;
        end
        if (r_b.plus) begin
            if (r_b.frac < unit_max) begin
                n_c_frac = r_b.frac + 30'd1;
            end else begin
                n_c_frac = '0;
                n_c_sec  = (r_b.sec < sec_max) ? r_b.sec + 64'd1 : '0;
            end
        end else if (r_b.minus) begin
            if (r_b.frac != '0) begin
                n_c_frac = r_b.frac - 30'd1;
            end else begin
                n_c_frac = unit_max;
                n_c_sec  = (r_b.sec != '0) ? r_b.sec - 64'd1 : sec_max;
            end
        end
    end

    // ---------------- pack stage ----------------
    always_comb begin
        logic [SEC_W+10:0] sec_w;
        logic [SEC_W+10:0] ms_total;
        sec_w     = {11'b0, r_c_sec};
        // seconds*1000 = seconds*1024 - seconds*16 - seconds*8
        ms_total  = (sec_w << 10) - (sec_w << 4) - (sec_w << 3)
                    + {{(SEC_W-FRAC_W+11){1'b0}}, r_c_frac};
        n_ts      = '0;
        n_short   = 1'b0;
        n_out_err = r_c_err;
        if (r_c_err == ERR_OK) begin
            if (r_c_fmt == FMT_NS) begin
                if (r_c_sec > SEC_MAX_NS) begin
                    n_out_err = ERR_TOO_LARGE;
                end else begin
                    n_ts    = {r_c_sec[31:0], 2'b00, r_c_frac};
                    n_short = (r_c_frac == '0);
                end
            end else begin
                if (ms_total[SEC_W+10:SEC_W] != 11'd0) begin
                    n_out_err = ERR_TOO_LARGE;
                end else begin
                    n_ts = ms_total[SEC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_b_valid <= in_acc && i_in.last_char;
            end
            if (b_ready) begin
                r_c_valid <= r_b_valid;
            end
            if (c_ready) begin
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_b <= n_b;
        end
        if (b_ready) begin
            r_c_sec  <= n_c_sec;
            r_c_frac <= n_c_frac;
            r_c_err  <= n_c_err;
            r_c_fmt  <= r_b.fmt;
        end
        if (c_ready) begin
            r_ts      <= n_ts;
            r_short   <= n_short;
            r_out_err <= n_out_err;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.timestamp  = r_ts;
    assign o_out.short_form = r_short;
    assign o_out.error_code = r_out_err;

endmodule

// ===== hdl/dtp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtp_checker
// Port-level checks on the timestamp parser result channel.
// ----------------------------------------------------------------------------
`include "decimal_timestamp_parser_top_defines.svh"

module dtp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_ready,
    input  logic [63:0] i_timestamp,
    input  logic        i_short_form,
    input  logic [2:0]  i_error_code
);
    import dtp_pkg::*;

    logic        out_stall;
    logic [67:0] res_bits;
    logic        err_res;
    logic        res_clear;
    logic        short_res;
    logic        short_ok;

    assign out_stall = i_valid && !i_ready;
    assign res_bits  = {i_timestamp, i_short_form, i_error_code};
    assign err_res   = i_valid && i_error_code != ERR_OK;
    assign res_clear = i_timestamp == 64'd0 && !i_short_form;
    assign short_res = i_valid && i_short_form;
    assign short_ok  = i_timestamp[31:0] == 32'd0 && i_error_code == ERR_OK;

    `DTP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_valid, "result dropped in stall")
    `DTP_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(res_bits), "result changed")
    `DTP_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, err_res, res_clear, "failed result has a value")
    `DTP_ASSERT_IMP(a_short_ns, i_clk, i_rst_n, short_res, short_ok, "bad short form")
    `DTP_ASSERT_NXT_ALL(a_rst_clear, i_clk, !i_rst_n, !i_valid, "result valid after reset")

endmodule

bind decimal_timestamp_parser_top dtp_checker u_dtp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_timestamp  (o_out.timestamp),
    .i_short_form (o_out.short_form),
    .i_error_code (o_out.error_code)
);
